// ===== sv/fdl_pkg.sv =====
// Shared constants, types and codes of the feedback delay line.
`timescale 1ns / 1ps

package fdl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int STORE_DEPTH = 131072;
  localparam int ADDR_BITS = $clog2(STORE_DEPTH);
  localparam int CNT_BITS = ADDR_BITS + 1;

  localparam int WHOLE_BITS = 17;
  localparam int FRAC_BITS = 8;
  localparam int GAIN_BITS = 16;
  localparam int GAIN_FRAC = 15;
  localparam int LEN_BITS = 18;
  localparam int CFG_DATA_BITS = 18;
  localparam int CFG_INDEX_BITS = 3;

  localparam int UNITY = 32768;
  localparam int LEN_RESET = 131072;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DELAY_WHOLE    = 3'd0,
    REG_DELAY_FRACTION = 3'd1,
    REG_FEEDBACK_GAIN  = 3'd2,
    REG_WET_LEVEL      = 3'd3,
    REG_LINE_LENGTH    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic addr;
    logic tap;
    logic old;
    logic interp;
    logic mult;
    logic write;
  } cmd_t;

endpackage

// ===== sv/fdl_if.sv =====
// Handshake channels of the feedback delay line: sample in, sample out, configuration.
`timescale 1ns / 1ps

interface fdl_in_if;
  logic valid;
  logic ready;
  logic signed [fdl_pkg::SAMPLE_BITS-1:0] in_sample;
  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

interface fdl_out_if;
  logic valid;
  logic ready;
  logic signed [fdl_pkg::SAMPLE_BITS-1:0] out_sample;
  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

interface fdl_cfg_if;
  logic valid;
  logic ready;
  logic [fdl_pkg::CFG_INDEX_BITS-1:0] index;
  logic [fdl_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/feedback_delay_line.sv =====
// Each accepted item passes in order through acceptance, address, two single-port reads of the
// delay store (tap and the entry one older), interpolation, the gain multiplies and write-back,
// its result then entering the output register; write-back waits while that register is full. A
// new item is accepted only once the previous one is written back. The output register lets the next
// item be accepted while a result still waits. Configuration writes are taken in any cycle but are
// meant for idle periods; writing the line length empties the store at once through a fill count.
`timescale 1ns / 1ps

module feedback_delay_line (
  input logic     clk,
  input logic     rst,
  fdl_in_if.sink  in_ch,
  fdl_out_if.source out_ch,
  fdl_cfg_if.sink cfg
);
  import fdl_pkg::*;

  cmd_t cmd;

  fdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  fdl_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_sample  (in_ch.in_sample),
    .out_sample (out_ch.out_sample)
  );

  a_write_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> (!out_ch.valid || out_ch.ready))
    else $error("Result written while the output register was still full.");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("More than one datapath step commanded at once.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("New item accepted while the previous one was in work.");

  a_result_follows_write: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> out_ch.valid)
    else $error("Output valid missing after write-back.");

endmodule

// ===== sv/fdl_ctrl.sv =====
// Sequencer that steps one item through address, read, interpolation, gain and write-back.
`timescale 1ns / 1ps

module fdl_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output fdl_pkg::cmd_t cmd
);
  import fdl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_TAP,
    S_OLD,
    S_INTERP,
    S_MULT,
    S_WRITE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.load = in_valid && in_ready;
      S_ADDR:   cmd.addr = 1'b1;
      S_TAP:    cmd.tap = 1'b1;
      S_OLD:    cmd.old = 1'b1;
      S_INTERP: cmd.interp = 1'b1;
      S_MULT:   cmd.mult = 1'b1;
      S_WRITE:  cmd.write = out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_ready <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (state == S_WRITE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_ADDR;
            in_ready <= 1'b0;
          end
        end
        S_ADDR:   state <= S_TAP;
        S_TAP:    state <= S_OLD;
        S_OLD:    state <= S_INTERP;
        S_INTERP: state <= S_MULT;
        S_MULT:   state <= S_WRITE;
        S_WRITE: begin
          if (out_free) begin
            state <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/fdl_datapath.sv =====
// Configuration registers, delay store and arithmetic of the feedback delay line.
`timescale 1ns / 1ps

module fdl_datapath (
  input  logic             clk,
  input  logic             rst,
  input  fdl_pkg::cmd_t    cmd,
  fdl_cfg_if.sink          cfg,
  input  fdl_pkg::sample_t in_sample,
  output fdl_pkg::sample_t out_sample
);
  import fdl_pkg::*;

  localparam int MW = SAMPLE_BITS + 20;
  localparam int WW = FRAC_BITS + 2;
  localparam int IW = SAMPLE_BITS + WW + 1;
  localparam int GW = GAIN_BITS + 2;
  localparam int PW = SAMPLE_BITS + GW;
  localparam logic signed [IW-1:0] ROUND_I = IW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [MW-1:0] ROUND_Q = MW'(2 ** (GAIN_FRAC - 1));
  localparam logic signed [MW-1:0] SAT_MAX =
    {{(MW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [MW-1:0] SAT_MIN = ~SAT_MAX;

  function automatic sample_t saturate(input logic signed [MW-1:0] v);
    sample_t r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  logic [WHOLE_BITS-1:0] delay_whole;
  logic [FRAC_BITS-1:0]  delay_fraction;
  logic [GAIN_BITS-1:0]  feedback_gain;
  logic [GAIN_BITS-1:0]  wet_level;
  logic [LEN_BITS-1:0]   line_length;
  logic                  cfg_fire;

  addr_t wp;
  cnt_t  fill;

  cnt_t  len_eff;
  cnt_t  len_m1;
  addr_t whole_eff;
  addr_t rd_next;
  addr_t old_next;
  addr_t rd_addr;
  addr_t old_addr;
  addr_t rd_sel;
  logic  rd_ok;
  logic  old_ok;

  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  sample_t mem_q;

  sample_t x_q;
  sample_t tap_q;
  sample_t y_q;
  sample_t older_v;
  sample_t y_next;
  sample_t store_sat;
  sample_t mix_sat;

  logic signed [WW-1:0] w_old;
  logic signed [WW-1:0] w_tap;
  logic signed [IW-1:0] i_sum;

  logic [GAIN_BITS:0]   g_eff;
  logic [GAIN_BITS:0]   w_eff;
  logic signed [GW-1:0] g_s;
  logic signed [GW-1:0] wy_s;
  logic signed [GW-1:0] wx_s;
  logic signed [PW-1:0] prod_fb;
  logic signed [PW-1:0] prod_wy;
  logic signed [PW-1:0] prod_wx;
  logic signed [MW-1:0] fb_sum;
  logic signed [MW-1:0] mix_sum;

  assign cfg.ready = 1'b1;
  assign cfg_fire = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_whole <= '0;
      delay_fraction <= '0;
      feedback_gain <= '0;
      wet_level <= '0;
      line_length <= LEN_BITS'(LEN_RESET);
    end else if (cfg_fire) begin
      unique case (cfg.index)
        REG_DELAY_WHOLE:    delay_whole <= cfg.data[WHOLE_BITS-1:0];
        REG_DELAY_FRACTION: delay_fraction <= cfg.data[FRAC_BITS-1:0];
        REG_FEEDBACK_GAIN:  feedback_gain <= cfg.data[GAIN_BITS-1:0];
        REG_WET_LEVEL:      wet_level <= cfg.data[GAIN_BITS-1:0];
        REG_LINE_LENGTH:    line_length <= cfg.data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Writes run from entry zero upward after a flush, so entries below the
  // fill count are exactly those written since; all others read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      fill <= '0;
    end else if (cfg_fire && cfg.index == REG_LINE_LENGTH) begin
      wp <= '0;
      fill <= '0;
    end else if (cmd.write) begin
      wp <= (cnt_t'(wp) == len_m1) ? '0 : wp + 1'b1;
      if (fill < len_eff) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_comb begin
    if (line_length == '0) begin
      len_eff = cnt_t'(1);
    end else if (32'(line_length) > 32'(STORE_DEPTH)) begin
      len_eff = cnt_t'(STORE_DEPTH);
    end else begin
      len_eff = cnt_t'(line_length);
    end
    len_m1 = len_eff - 1'b1;
    if (32'(delay_whole) > 32'(len_m1)) begin
      whole_eff = len_m1[ADDR_BITS-1:0];
    end else begin
      whole_eff = addr_t'(delay_whole);
    end
    if (wp >= whole_eff) begin
      rd_next = wp - whole_eff;
    end else begin
      rd_next = addr_t'(cnt_t'(wp) + len_eff - cnt_t'(whole_eff));
    end
    old_next = (rd_addr == '0) ? len_m1[ADDR_BITS-1:0] : rd_addr - 1'b1;
    rd_sel = cmd.tap ? rd_addr : old_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wp] <= store_sat;
    end
    if (cmd.tap || cmd.old) begin
      mem_q <= mem[rd_sel];
    end
  end

  always_comb begin
    w_old = WW'(delay_fraction);
    w_tap = WW'(2 ** FRAC_BITS) - w_old;
    older_v = old_ok ? mem_q : '0;
    i_sum = IW'(tap_q) * IW'(w_tap) + IW'(older_v) * IW'(w_old) + ROUND_I;
    y_next = i_sum[FRAC_BITS +: SAMPLE_BITS];

    g_eff = (32'(feedback_gain) > 32'(UNITY)) ? (GAIN_BITS + 1)'(UNITY)
                                              : {1'b0, feedback_gain};
    w_eff = (32'(wet_level) > 32'(UNITY)) ? (GAIN_BITS + 1)'(UNITY)
                                          : {1'b0, wet_level};
    g_s = GW'(g_eff);
    wy_s = GW'(w_eff);
    wx_s = GW'(UNITY) - wy_s;

    fb_sum = (MW'(prod_fb) + ROUND_Q) >>> GAIN_FRAC;
    store_sat = saturate(MW'(x_q) + fb_sum);
    mix_sum = (MW'(prod_wy) + MW'(prod_wx) + ROUND_Q) >>> GAIN_FRAC;
    mix_sat = saturate(mix_sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_q <= in_sample;
    end
    if (cmd.addr) begin
      rd_addr <= rd_next;
    end
    if (cmd.tap) begin
      old_addr <= old_next;
      rd_ok <= cnt_t'(rd_addr) < fill;
    end
    if (cmd.old) begin
      old_ok <= cnt_t'(old_addr) < fill;
      if (delay_whole == '0) begin
        tap_q <= x_q;
      end else begin
        tap_q <= rd_ok ? mem_q : '0;
      end
    end
    if (cmd.interp) begin
      y_q <= y_next;
    end
    if (cmd.mult) begin
      prod_fb <= PW'(y_q) * PW'(g_s);
      prod_wy <= PW'(y_q) * PW'(wy_s);
      prod_wx <= PW'(x_q) * PW'(wx_s);
    end
    if (cmd.write) begin
      out_sample <= mix_sat;
    end
  end

endmodule
